// ===== rtl/otat_pkg.sv =====
package otat_pkg;

	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_SWEEP   = 1'b1;

	localparam logic [1:0] CFG_GATE  = 2'd0;
	localparam logic [1:0] CFG_DECAY = 2'd1;
	localparam logic [1:0] CFG_MINC  = 2'd2;
	localparam logic [1:0] CFG_SWEEP = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef struct packed {
		logic               command;
		logic [7:0]         obj_class;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [15:0]        radius_mm;
		logic [7:0]         confidence;
		logic [31:0]        time_ms;
	} in_item_t;

	typedef struct packed {
		logic [4:0] slot;
		logic       matched;
		logic       inserted;
		logic       dropped_full;
		logic [5:0] removed_count;
		logic [5:0] live_count;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  cls;
		logic [23:0] x;
		logic [23:0] y;
		logic [15:0] radius;
		logic [7:0]  conf;
		logic [31:0] seen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/object_track_association_table.sv =====
// After acceptance the item passes ST_MUL, then ST_SCAN reads the N entries held at
// acceptance, one entry per cycle through a two-stage pipeline, then ST_DECIDE and ST_OUT.
// One item at a time: a new item is accepted only in ST_IDLE, after the last result is set.
// A result left waiting holds the next item at the end of its scan.
// Reset clears the entry count and the control registers; memory contents stay undefined.
module object_track_association_table import otat_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_OUT   = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;

	logic [15:0] gate_q;
	logic [31:0] decay_q;
	logic [7:0]  minc_q;
	logic        sweep_en_q;

	otat_cfg u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.gate_q, .decay_q, .minc_q, .sweep_en_q
	);

	logic [2:0]  state_q;
	in_item_t    item_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] keep_q;
	logic [CW-1:0] removed_q;
	logic [31:0]   best_q;
	logic [AW-1:0] hit_q;
	logic          found_q;
	logic [39:0]   thresh_q;
	out_item_t     res_q;
	out_item_t     res_c;
	logic          out_valid_q;

	// Read pipeline: stage 1 holds memory data, stage 2 the computed metrics.
	logic          v_s1, v_s2;
	logic [AW-1:0] idx_s1, idx_s2;
	entry_t        ent_s2;
	logic          cls_eq_s2;
	logic [47:0]   dx2_s2, dy2_s2;
	logic signed [41:0] lhs_s2;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	assign ram_rdata = entry_t'(ram_rbits);
	assign ram_raddr = rd_idx_q[AW-1:0];

	otat_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ENTRY_W'(ram_wdata)),
		.raddr(ram_raddr), .rdata(ram_rbits)
	);

	logic scan_issue;
	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q < count_q);

	logic signed [24:0] dx_c, dy_c;
	logic [31:0] age_c;
	logic signed [33:0] rem_c;
	assign dx_c  = 25'(signed'(ram_rdata.x)) - 25'(item_q.pos_x);
	assign dy_c  = 25'(signed'(ram_rdata.y)) - 25'(item_q.pos_y);
	assign age_c = item_q.time_ms - ram_rdata.seen;
	assign rem_c = 34'(signed'({1'b0, decay_q})) - 34'(signed'({1'b0, age_c}));

	logic [48:0] d2_c;
	logic        kill_c;
	assign d2_c   = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign kill_c = sweep_en_q && (lhs_s2 < signed'({2'b00, thresh_q}));

	logic entry_cand;
	assign entry_cand = cls_eq_s2 && (d2_c < {17'd0, best_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ent_s2;
		if (state_q == ST_SCAN && v_s2 && item_q.command == CMD_SWEEP && !kill_c) begin
			ram_we    = (keep_q[AW-1:0] != idx_s2);
			ram_waddr = keep_q[AW-1:0];
		end else if (state_q == ST_DECIDE && item_q.command == CMD_OBSERVE
				&& (found_q || count_q < CW'(TABLE_DEPTH))) begin
			ram_we    = 1'b1;
			ram_waddr = found_q ? hit_q : count_q[AW-1:0];
			ram_wdata = '{cls: item_q.obj_class, x: item_q.pos_x, y: item_q.pos_y,
				radius: item_q.radius_mm, conf: item_q.confidence, seen: item_q.time_ms};
		end
	end

	always_comb begin
		res_c = '0;
		if (item_q.command == CMD_SWEEP) begin
			res_c.removed_count = 6'(removed_q);
			res_c.live_count    = 6'(keep_q);
		end else if (found_q) begin
			res_c.slot       = 5'(hit_q);
			res_c.matched    = 1'b1;
			res_c.live_count = 6'(count_q);
		end else if (count_q < CW'(TABLE_DEPTH)) begin
			res_c.slot       = 5'(count_q);
			res_c.inserted   = 1'b1;
			res_c.live_count = 6'(count_q + 1'b1);
		end else begin
			res_c.dropped_full = 1'b1;
			res_c.live_count   = 6'(count_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = res_q;

	always_ff @(posedge clk) begin
		idx_s1    <= rd_idx_q[AW-1:0];
		idx_s2    <= idx_s1;
		ent_s2    <= ram_rdata;
		cls_eq_s2 <= ram_rdata.cls == item_q.obj_class;
		dx2_s2    <= 48'(unsigned'(50'(dx_c * dx_c)));
		dy2_s2    <= 48'(unsigned'(50'(dy_c * dy_c)));
		lhs_s2    <= 42'(signed'({1'b0, ram_rdata.conf})) * 42'(rem_c);
		if (state_q == ST_MUL) begin
			thresh_q <= 40'(minc_q) * 40'(decay_q);
			best_q   <= 32'(gate_q) * 32'(gate_q);
		end else if (state_q == ST_SCAN && v_s2 && item_q.command == CMD_OBSERVE
				&& entry_cand) begin
			best_q <= d2_c[31:0];
		end
		if (state_q == ST_SCAN && v_s2 && entry_cand) begin
			hit_q <= idx_s2;
		end
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			keep_q      <= '0;
			removed_q   <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q   <= ST_MUL;
						rd_idx_q  <= '0;
						keep_q    <= '0;
						removed_q <= '0;
						found_q   <= 1'b0;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (v_s2) begin
						if (item_q.command == CMD_OBSERVE) begin
							if (entry_cand) begin
								found_q <= 1'b1;
							end
						end else if (kill_c) begin
							removed_q <= removed_q + 1'b1;
						end else begin
							keep_q <= keep_q + 1'b1;
						end
					end
					if (!scan_issue && !v_s1 && !v_s2 && !out_valid_q) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					res_q <= res_c;
					if (item_q.command == CMD_SWEEP) begin
						count_q <= keep_q;
					end else if (!found_q && count_q < CW'(TABLE_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("entry count above depth");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones({res_q.matched, res_q.inserted, res_q.dropped_full}) <= 1)
		else $error("more than one outcome flag");
	a_keep_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ram_we) |-> (ram_waddr < idx_s2))
		else $error("compaction writes ahead of read");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");

endmodule

// ===== rtl/otat_ram.sv =====
module otat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/otat_cfg.sv =====
module otat_cfg import otat_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [15:0]           gate_q,
	output logic [31:0]           decay_q,
	output logic [7:0]            minc_q,
	output logic                  sweep_en_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q     <= 16'd750;
			decay_q    <= 32'd3000;
			minc_q     <= 8'd51;
			sweep_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GATE:  gate_q     <= cfg_data[15:0];
				CFG_DECAY: decay_q    <= cfg_data;
				CFG_MINC:  minc_q     <= cfg_data[7:0];
				CFG_SWEEP: sweep_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
